@@ hdl/cht_pkg.sv @@
// package for the chained hash table unit
// holds item types, status codes and sequencer states; no dependencies
package cht_pkg;

  localparam int MaxBuckets = 64;
  localparam int PoolNodes  = 256;
  localparam int KeyW       = 31;
  localparam int ValW       = 32;
  localparam int CfgW       = 7;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic            action;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t         status;
    logic [ValW-1:0] found_value;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_HEADWAIT,
    S_FETCH,
    S_CHECK,
    S_OUT
  } state_t;

endpackage

@@ hdl/chained_hash_table_unit.sv @@
// chained hash table unit: top level, single module
// depends on cht_pkg for item types, status codes and states
//
// usage: one input channel (in_valid / in_stall / in_data) carries insert or
// search items; one output channel (out_valid / out_stall / out_data) returns
// exactly one result item per input item. bucket_count is written through
// cfg_we / cfg_data while the block is idle.
// after acceptance the restoring divider works out the bucket index (one key
// bit per cycle, S_MOD), the bucket head is read (S_HEAD, S_HEADWAIT), then
// each chain node visited takes one node memory read (S_FETCH) and one key
// compare (S_CHECK). a hit ends the walk at that node and goes to S_OUT; a
// walk that ends without a match needs one more fetch, which sets the not-found,
// full or inserted result, before S_OUT.
// the block takes one item at a time: in_stall stays high from acceptance
// until its result has been taken. a stalled result holds in the output
// register. reset clears the bucket heads (valid bits), the node count and
// the control; node contents are undefined until written.
module chained_hash_table_unit #(
  parameter int MAX_BUCKETS = cht_pkg::MaxBuckets,
  parameter int POOL_NODES  = cht_pkg::PoolNodes
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  cht_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output cht_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic [cht_pkg::CfgW-1:0] cfg_data
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES) + 1;
  localparam int AW = $clog2(POOL_NODES);
  localparam int KW = cht_pkg::KeyW;
  localparam int VW = cht_pkg::ValW;
  localparam int DW = (BW + 1 > cht_pkg::CfgW) ? BW + 1 : cht_pkg::CfgW;
  localparam int CW = $clog2(KW + 1);
  localparam logic [NW-1:0] NullLink = NW'(POOL_NODES);

  // memories
  logic [KW-1:0] node_key   [POOL_NODES];
  logic [VW-1:0] node_value [POOL_NODES];
  logic [NW-1:0] node_link  [POOL_NODES];
  logic [NW-1:0] bucket_head [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_ok;

  cht_pkg::state_t state, state_next;
  logic [cht_pkg::CfgW-1:0] bucket_count;
  logic [NW-1:0] nodes_used;
  cht_pkg::in_item_t item;
  logic [DW-1:0] divisor;
  logic [DW:0]   rem;
  logic [CW-1:0] bit_cnt;
  logic [BW-1:0] bucket;
  logic [NW-1:0] cur;
  logic [NW-1:0] head_rd;
  logic [NW:0]   steps;
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_value;
  logic [NW-1:0] rd_link;
  cht_pkg::out_item_t result;

  // effective divisor: zero is one bucket, saturate at the maximum
  logic [DW-1:0] eff;
  always_comb begin
    if (bucket_count == '0) eff = DW'(1);
    else if (DW'(bucket_count) > DW'(MAX_BUCKETS)) eff = DW'(MAX_BUCKETS);
    else eff = DW'(bucket_count);
  end

  logic [DW:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem[DW-1:0], item.key[CW'(KW - 1) - bit_cnt]};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  logic walk_ok;
  assign walk_ok = (cur < nodes_used) && (cur < NullLink) && (steps < (NW+1)'(POOL_NODES));

  always_comb begin
    state_next = state;
    unique case (state)
      cht_pkg::S_IDLE:     if (in_valid) state_next = cht_pkg::S_MOD;
      cht_pkg::S_MOD:      if (bit_cnt == CW'(KW - 1)) state_next = cht_pkg::S_HEAD;
      cht_pkg::S_HEAD:     state_next = cht_pkg::S_HEADWAIT;
      cht_pkg::S_HEADWAIT: state_next = cht_pkg::S_FETCH;
      cht_pkg::S_FETCH:    state_next = walk_ok ? cht_pkg::S_CHECK : cht_pkg::S_OUT;
      cht_pkg::S_CHECK: begin
        if (rd_key == item.key) state_next = cht_pkg::S_OUT;
        else state_next = cht_pkg::S_FETCH;
      end
      cht_pkg::S_OUT:      if (!out_stall) state_next = cht_pkg::S_IDLE;
      default:             state_next = cht_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state != cht_pkg::S_IDLE);
  assign out_valid = (state == cht_pkg::S_OUT);
  assign out_data  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cht_pkg::S_IDLE;
      bucket_count <= cht_pkg::CfgW'(64);
      nodes_used   <= '0;
      head_ok      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) bucket_count <= cfg_data;
      // insert of a new node happens on the fetch that ends the walk
      if (state == cht_pkg::S_FETCH && !walk_ok && item.action == cht_pkg::ACT_INSERT
          && nodes_used < NullLink) begin
        nodes_used      <= nodes_used + NW'(1);
        head_ok[bucket] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      cht_pkg::S_IDLE: begin
        item    <= in_data;
        divisor <= eff;
        rem     <= '0;
        bit_cnt <= '0;
        steps   <= '0;
      end
      cht_pkg::S_MOD: begin
        rem     <= rem_ge ? rem_sh - {1'b0, divisor} : rem_sh;
        bit_cnt <= bit_cnt + CW'(1);
      end
      cht_pkg::S_HEAD: begin
        bucket  <= rem[BW-1:0];
        head_rd <= bucket_head[rem[BW-1:0]];
      end
      cht_pkg::S_HEADWAIT: cur <= head_ok[bucket] ? head_rd : NullLink;
      cht_pkg::S_FETCH: begin
        rd_key   <= node_key[cur[AW-1:0]];
        rd_value <= node_value[cur[AW-1:0]];
        rd_link  <= node_link[cur[AW-1:0]];
        if (!walk_ok) begin
          result.found_value <= '0;
          if (item.action == cht_pkg::ACT_SEARCH) begin
            result.status <= cht_pkg::ST_NOT_FOUND;
          end else if (nodes_used >= NullLink) begin
            result.status <= cht_pkg::ST_FULL;
          end else begin
            result.status               <= cht_pkg::ST_INSERTED;
            node_key[nodes_used[AW-1:0]]   <= item.key;
            node_value[nodes_used[AW-1:0]] <= item.value;
            node_link[nodes_used[AW-1:0]]  <= head_ok[bucket] ? head_rd : NullLink;
            bucket_head[bucket]            <= nodes_used;
          end
        end
      end
      cht_pkg::S_CHECK: begin
        steps <= steps + (NW+1)'(1);
        cur   <= rd_link;
        if (rd_key == item.key) begin
          if (item.action == cht_pkg::ACT_SEARCH) begin
            result.status      <= cht_pkg::ST_FOUND;
            result.found_value <= rd_value;
          end else begin
            result.status           <= cht_pkg::ST_UPDATED;
            result.found_value      <= '0;
            node_value[cur[AW-1:0]] <= item.value;
          end
        end
      end
      cht_pkg::S_OUT: ;
      default: ;
    endcase
  end

endmodule
